@@ rtl/core/avm_pkg.sv @@
`timescale 1ns / 1ps

package avm_pkg;

  localparam int SLOT_COUNT_DEFAULT = 128;
  localparam int WORD_COUNT = 8;
  localparam int WORD_AW = 3;
  localparam int OPND_W = 33;
  localparam int PROD_W = 66;
  localparam int VAL_W = 43;

  localparam logic CMD_MAP = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [3:0] SEL_MODE = 4'd0;
  localparam logic [3:0] SEL_LAST = 4'd8;

  localparam logic [2:0] W_CENTRE = 3'd0;
  localparam logic [2:0] W_NEG_RANGE = 3'd1;
  localparam logic [2:0] W_POS_RANGE = 3'd2;
  localparam logic [2:0] W_OUT_MAX = 3'd3;
  localparam logic [2:0] W_DEADZONE = 3'd4;
  localparam logic [2:0] W_IN_MIN = 3'd5;
  localparam logic [2:0] W_IN_MAX = 3'd6;
  localparam logic [2:0] W_OUT_MIN = 3'd7;

  localparam logic [PROD_W-1:0] MAG_CAP = PROD_W'(1) << 40;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_CENTRE_NEG = 2'd2,
    MODE_CENTRE_POS = 2'd3
  } avm_mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SETUP,
    ST_CALC,
    ST_POST,
    ST_FIN,
    ST_OUT
  } avm_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } avm_md_state_t;

endpackage

@@ rtl/core/axis_value_mapper.sv @@
`timescale 1ns / 1ps

// channel  | signals                        | payload
// s        | s_tvalid s_tready s_tdata/user | one command: sample or parameter write
// m        | m_tvalid m_tready m_tdata      | slot, stored value, negative/positive parts
//
// a write or an unmapped sample goes from the fetch and setup states straight to output
// a centre sample with a zero range skips the muldiv and takes the post and fin states
// a mapped sample first runs the bit-serial multiply and divide unit, then post and fin
// reset starts a clearing pass over the parameter memory and the slot mode memory
// s_tready is low during the clearing pass and while an item is in work
// a finished beat waits in the output register while the next item is taken

module axis_value_mapper #(
  parameter int SLOT_COUNT = avm_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // slot[6:0], data_value[38:7], zero
  input  logic [4:0]   s_tuser,   // command[0], word_select[4:1]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // result_slot, mapped_result, negative_part,
                                  // positive_part, zero
);

  localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PW_AW = SLOT_AW + avm_pkg::WORD_AW;
  localparam int PW_DEPTH = SLOT_COUNT * avm_pkg::WORD_COUNT;
  localparam int VW = avm_pkg::VAL_W;

  avm_pkg::avm_state_t state, state_next;

  logic                cmd;
  logic [6:0]          slot_r;
  logic [3:0]          sel;
  logic signed [31:0]  x;
  logic [3:0]          cnt;
  logic signed [31:0]  p [avm_pkg::WORD_COUNT];
  avm_pkg::avm_mode_t  mode;
  logic [31:0]         mapped;
  logic [PW_AW-1:0]    clr;
  logic                neg;
  logic                lin;
  logic [avm_pkg::PROD_W-1:0] q_r;
  logic signed [VW-1:0] nval;
  logic [31:0]         res_mapped;
  logic [30:0]         res_neg;
  logic [30:0]         res_pos;

  logic                in_ok;
  logic [SLOT_AW-1:0]  slot_idx;
  logic [2:0]          fetch_idx;

  logic                pw_we;
  logic [PW_AW-1:0]    pw_waddr;
  logic [31:0]         pw_wdata;
  logic [31:0]         pw_rdata;
  logic                sm_we;
  logic [SLOT_AW-1:0]  sm_waddr;
  logic [33:0]         sm_wdata;
  logic [33:0]         sm_rdata;

  logic signed [32:0]  span, d_lin, r_lin, c_cen;
  logic signed [31:0]  range_w;
  logic                c_le0;
  logic                lin_go, cen_go, cen_zero;
  logic [32:0]         md_a, md_b, md_dv;
  logic                md_neg;
  logic                md_start;
  logic [avm_pkg::PROD_W-1:0] md_q;
  logic                md_done;
  logic                md_busy;

  logic signed [VW-1:0] post_val;
  logic [31:0]         fin_mapped;
  logic [30:0]         fin_neg, fin_pos;
  logic                out_free;

  assign in_ok = 32'(s_tdata[6:0]) < SLOT_COUNT;
  assign slot_idx = SLOT_AW'(slot_r);
  assign fetch_idx = cnt[2:0] - 3'd1;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == avm_pkg::ST_IDLE);

  avm_store #(.SLOT_COUNT(SLOT_COUNT)) u_store (
    .clk      (clk),
    .pw_we    (pw_we),
    .pw_waddr (pw_waddr),
    .pw_wdata (pw_wdata),
    .pw_raddr ({slot_idx, cnt[2:0]}),
    .pw_rdata (pw_rdata),
    .sm_we    (sm_we),
    .sm_waddr (sm_waddr),
    .sm_wdata (sm_wdata),
    .sm_raddr (slot_idx),
    .sm_rdata (sm_rdata)
  );

  avm_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .dv    (md_dv),
    .q     (md_q),
    .done  (md_done),
    .busy  (md_busy)
  );

  // operand setup
  always_comb begin
    span = 33'(p[avm_pkg::W_IN_MAX]) - 33'(p[avm_pkg::W_IN_MIN]);
    d_lin = 33'(x) - 33'(p[avm_pkg::W_IN_MIN]);
    r_lin = 33'(p[avm_pkg::W_OUT_MAX]) - 33'(p[avm_pkg::W_OUT_MIN]);
    c_cen = 33'(x) - 33'(p[avm_pkg::W_CENTRE]);
    c_le0 = c_cen[32] || (c_cen == '0);
    range_w = c_le0 ? p[avm_pkg::W_NEG_RANGE] : p[avm_pkg::W_POS_RANGE];
    lin_go = (mode == avm_pkg::MODE_LINEAR) && !span[32] && (span != '0);
    cen_go = mode[1] && (range_w != '0);
    cen_zero = mode[1] && (range_w == '0);
    if (mode == avm_pkg::MODE_LINEAR) begin
      md_a = d_lin[32] ? -d_lin : d_lin;
      md_b = r_lin[32] ? -r_lin : r_lin;
      md_dv = span;
      md_neg = d_lin[32] ^ r_lin[32];
    end else begin
      md_a = c_cen[32] ? -c_cen : c_cen;
      md_b = p[avm_pkg::W_OUT_MAX][31] ? -33'(p[avm_pkg::W_OUT_MAX])
                                        : 33'(p[avm_pkg::W_OUT_MAX]);
      md_dv = range_w[31] ? -33'(range_w) : 33'(range_w);
      md_neg = c_cen[32] ^ p[avm_pkg::W_OUT_MAX][31] ^ range_w[31];
    end
  end

  // cap, sign and, in linear mode, offset
  always_comb begin
    logic [40:0] capped;
    logic signed [VW-1:0] sv;
    capped = (q_r > avm_pkg::MAG_CAP) ? 41'(avm_pkg::MAG_CAP) : q_r[40:0];
    sv = neg ? -VW'(capped) : VW'(capped);
    post_val = lin ? sv + VW'(p[avm_pkg::W_OUT_MIN]) : sv;
  end

  // saturate, clamp, deadzone and split
  always_comb begin
    logic signed [VW-1:0] n, omax, dz;
    logic [VW-1:0] mag;
    n = nval;
    omax = VW'(p[avm_pkg::W_OUT_MAX]);
    dz = VW'(p[avm_pkg::W_DEADZONE]);
    fin_neg = '0;
    fin_pos = '0;
    if (n > omax) begin
      n = omax;
    end else if (n < -omax) begin
      n = -omax;
    end
    if (n > -dz && n < dz) begin
      n = '0;
    end
    mag = n[VW-1] ? -n : n;
    if (n <= 0) begin
      fin_neg = (mag > VW'(32'h7fffffff)) ? 31'h7fffffff : mag[30:0];
    end else begin
      fin_pos = (mag > VW'(32'h7fffffff)) ? 31'h7fffffff : mag[30:0];
    end
    if (lin) begin
      if (nval > VW'(32'sh7fffffff)) begin
        fin_mapped = 32'h7fffffff;
      end else if (nval < -VW'(33'sh080000000)) begin
        fin_mapped = 32'h80000000;
      end else begin
        fin_mapped = nval[31:0];
      end
    end else begin
      fin_mapped = (mode == avm_pkg::MODE_CENTRE_NEG) ? {1'b0, fin_neg} : {1'b0, fin_pos};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      avm_pkg::ST_CLEAR: begin
        if (clr == PW_AW'(PW_DEPTH - 1)) state_next = avm_pkg::ST_IDLE;
      end
      avm_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = in_ok ? avm_pkg::ST_FETCH : avm_pkg::ST_OUT;
      end
      avm_pkg::ST_FETCH: begin
        if (cnt == 4'd8) state_next = avm_pkg::ST_SETUP;
      end
      avm_pkg::ST_SETUP: begin
        if (cmd == avm_pkg::CMD_WRITE) begin
          state_next = avm_pkg::ST_OUT;
        end else if (lin_go || cen_go) begin
          state_next = avm_pkg::ST_CALC;
        end else if (cen_zero) begin
          state_next = avm_pkg::ST_POST;
        end else begin
          state_next = avm_pkg::ST_OUT;
        end
      end
      avm_pkg::ST_CALC: begin
        if (md_done) state_next = avm_pkg::ST_POST;
      end
      avm_pkg::ST_POST: state_next = avm_pkg::ST_FIN;
      avm_pkg::ST_FIN: state_next = avm_pkg::ST_OUT;
      avm_pkg::ST_OUT: begin
        if (out_free) state_next = avm_pkg::ST_IDLE;
      end
      default: state_next = avm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    pw_we = 1'b0;
    pw_waddr = clr;
    pw_wdata = '0;
    sm_we = 1'b0;
    sm_waddr = clr[PW_AW-1:avm_pkg::WORD_AW];
    sm_wdata = '0;
    md_start = 1'b0;
    case (state)
      avm_pkg::ST_CLEAR: begin
        pw_we = 1'b1;
        sm_we = 1'b1;
      end
      avm_pkg::ST_SETUP: begin
        if (cmd == avm_pkg::CMD_WRITE) begin
          if (sel == avm_pkg::SEL_MODE) begin
            sm_we = 1'b1;
            sm_waddr = slot_idx;
            sm_wdata = {x[1:0], mapped};
          end else if (sel <= avm_pkg::SEL_LAST) begin
            pw_we = 1'b1;
            pw_waddr = {slot_idx, 3'(sel - 4'd1)};
            pw_wdata = x;
          end
        end else begin
          md_start = lin_go || cen_go;
        end
      end
      avm_pkg::ST_FIN: begin
        sm_we = 1'b1;
        sm_waddr = slot_idx;
        sm_wdata = {mode, fin_mapped};
      end
      default: begin
        pw_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avm_pkg::ST_CLEAR;
      clr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == avm_pkg::ST_CLEAR) begin
        clr <= clr + PW_AW'(1);
      end
      if (state == avm_pkg::ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      avm_pkg::ST_IDLE: begin
        cmd <= s_tuser[0];
        sel <= s_tuser[4:1];
        slot_r <= s_tdata[6:0];
        x <= s_tdata[38:7];
        cnt <= '0;
        res_mapped <= '0;
        res_neg <= '0;
        res_pos <= '0;
      end
      avm_pkg::ST_FETCH: begin
        cnt <= cnt + 4'd1;
        if (cnt != 4'd0) begin
          p[fetch_idx] <= pw_rdata;
        end
        if (cnt == 4'd1) begin
          mode <= avm_pkg::avm_mode_t'(sm_rdata[33:32]);
          mapped <= sm_rdata[31:0];
          res_mapped <= sm_rdata[31:0];
        end
      end
      avm_pkg::ST_SETUP: begin
        neg <= md_neg;
        lin <= (mode == avm_pkg::MODE_LINEAR);
        q_r <= '0;
      end
      avm_pkg::ST_CALC: begin
        if (md_done) q_r <= md_q;
      end
      avm_pkg::ST_POST: begin
        nval <= post_val;
      end
      avm_pkg::ST_FIN: begin
        res_mapped <= fin_mapped;
        res_neg <= lin ? 31'd0 : fin_neg;
        res_pos <= lin ? 31'd0 : fin_pos;
      end
      avm_pkg::ST_OUT: begin
        if (out_free) begin
          m_tdata <= {3'd0, res_pos, res_neg, res_mapped, slot_r};
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == avm_pkg::ST_CLEAR) |-> !s_tready) else $error("input taken during clear");
  a_start_setup: assert property (@(posedge clk) disable iff (rst)
    md_start |-> (state == avm_pkg::ST_SETUP) && !md_busy) else $error("bad muldiv start");
  a_pw_write: assert property (@(posedge clk) disable iff (rst)
    pw_we |-> (state == avm_pkg::ST_CLEAR) || (state == avm_pkg::ST_SETUP))
    else $error("parameter write outside clear or setup");
  a_beat_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == avm_pkg::ST_OUT)) else $error("beat not from out state");

endmodule

@@ rtl/core/avm_store.sv @@
`timescale 1ns / 1ps

module avm_store #(
  parameter int SLOT_COUNT = avm_pkg::SLOT_COUNT_DEFAULT,
  localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int PW_AW = SLOT_AW + avm_pkg::WORD_AW,
  localparam int PW_DEPTH = SLOT_COUNT * avm_pkg::WORD_COUNT
) (
  input  logic               clk,
  input  logic               pw_we,
  input  logic [PW_AW-1:0]   pw_waddr,
  input  logic [31:0]        pw_wdata,
  input  logic [PW_AW-1:0]   pw_raddr,
  output logic [31:0]        pw_rdata,
  input  logic               sm_we,
  input  logic [SLOT_AW-1:0] sm_waddr,
  input  logic [33:0]        sm_wdata,
  input  logic [SLOT_AW-1:0] sm_raddr,
  output logic [33:0]        sm_rdata
);

  logic [31:0] pw_mem [PW_DEPTH];
  logic [33:0] sm_mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (pw_we) begin
      pw_mem[pw_waddr] <= pw_wdata;
    end
    pw_rdata <= pw_mem[pw_raddr];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      sm_mem[sm_waddr] <= sm_wdata;
    end
    sm_rdata <= sm_mem[sm_raddr];
  end

endmodule

@@ rtl/core/avm_muldiv.sv @@
`timescale 1ns / 1ps

module avm_muldiv (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [avm_pkg::OPND_W-1:0]        a,
  input  logic [avm_pkg::OPND_W-1:0]        b,
  input  logic [avm_pkg::OPND_W-1:0]        dv,
  output logic [avm_pkg::PROD_W-1:0]        q,
  output logic                              done,
  output logic                              busy
);

  avm_pkg::avm_md_state_t state, state_next;
  logic [6:0]                       cnt;
  logic [avm_pkg::PROD_W-1:0]       mcand;
  logic [avm_pkg::OPND_W-1:0]       mplier;
  logic [avm_pkg::PROD_W-1:0]       acc;
  logic [avm_pkg::OPND_W-1:0]       dvsr;
  logic [avm_pkg::OPND_W:0]         rem;
  logic [avm_pkg::OPND_W:0]         rem_sh;
  logic                             fits;
  logic [avm_pkg::PROD_W-1:0]       acc_next;

  assign acc_next = mplier[0] ? acc + mcand : acc;
  assign rem_sh = {rem[avm_pkg::OPND_W-1:0], q[avm_pkg::PROD_W-1]};
  assign fits = rem_sh >= {1'b0, dvsr};

  always_comb begin
    state_next = state;
    case (state)
      avm_pkg::MD_IDLE: if (start) state_next = avm_pkg::MD_MUL;
      avm_pkg::MD_MUL: if (cnt == 7'(avm_pkg::OPND_W - 1)) state_next = avm_pkg::MD_DIV;
      avm_pkg::MD_DIV: if (cnt == 7'(avm_pkg::PROD_W - 1)) state_next = avm_pkg::MD_IDLE;
      default: state_next = avm_pkg::MD_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != avm_pkg::MD_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avm_pkg::MD_IDLE;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == avm_pkg::MD_DIV) && (cnt == 7'(avm_pkg::PROD_W - 1));
      if (state == avm_pkg::MD_IDLE || state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      avm_pkg::MD_IDLE: begin
        if (start) begin
          mcand <= avm_pkg::PROD_W'(a);
          mplier <= b;
          dvsr <= dv;
          acc <= '0;
        end
      end
      avm_pkg::MD_MUL: begin
        acc <= acc_next;
        mcand <= {mcand[avm_pkg::PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[avm_pkg::OPND_W-1:1]};
        if (cnt == 7'(avm_pkg::OPND_W - 1)) begin
          q <= acc_next;
          rem <= '0;
        end
      end
      avm_pkg::MD_DIV: begin
        rem <= fits ? rem_sh - {1'b0, dvsr} : rem_sh;
        q <= {q[avm_pkg::PROD_W-2:0], fits};
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("muldiv started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("muldiv done longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("muldiv done while busy");

endmodule
